// ===== rtl/eaa_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Euler angle to axes pipeline.
package eaa_pkg;

  // Signed Q30 value, 2^30 means 1.0.
  typedef logic signed [31:0] q30_t;
  // Sum of two Q30 products.
  typedef logic signed [32:0] sum_t;

  localparam int ANGLE_W   = 16;
  localparam int FIELD_W   = 16;
  localparam int SC_STAGES = 8;
  localparam int MX_STAGES = 4;
  localparam int STAGES    = SC_STAGES + MX_STAGES;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Odd polynomial for sin(pi/2 * t), Q30 coefficients, lowest order first.
  localparam logic [30:0] SIN_COEF [6] = '{
    31'd1686629713, 31'd693598669, 31'd85569305, 31'd5026995, 31'd172272, 31'd3864
  };

  // Unsigned Q30 product truncated by 30 bits; both operands stay below 2^31.
  function automatic logic [30:0] mul_shr(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = {31'b0, a} * {31'b0, b};
    return p[60:30];
  endfunction

  // Signed Q30 product rounded to nearest, halves away from zero.
  function automatic q30_t q30_mul(input q30_t a, input q30_t b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [61:0] r;
    logic [31:0] rm;
    ma = a[31] ? 31'(-a) : a[30:0];
    mb = b[31] ? 31'(-b) : b[30:0];
    p  = {31'b0, ma} * {31'b0, mb};
    r  = (p + 62'd536870912) >> 30;
    rm = r[31:0];
    return (a[31] ^ b[31]) ? -rm : rm;
  endfunction

endpackage

// ===== rtl/eaa_sincos.sv =====
// Pipelined sine and cosine of one angle given as a fraction of a full turn.
module eaa_sincos #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic [eaa_pkg::SC_STAGES-1:0]        en,
  input  logic [eaa_pkg::ANGLE_W-1:0]          angle,
  output eaa_pkg::q30_t                        sin_val,
  output eaa_pkg::q30_t                        cos_val
);

  localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  logic [ANGLE_BITS-1:0] a;
  logic [ANGLE_BITS-1:0] ac;

  logic [30:0]   t_q   [0:6][0:1];
  logic [1:0]    neg_q [0:6];
  logic [30:0]   z_q   [1:5][0:1];
  logic [30:0]   p_q   [2:6][0:1];
  eaa_pkg::q30_t out_q [0:1];

  // Folds an angle into a quarter-turn fraction t and a sign; {neg, t}.
  function automatic logic [31:0] fold(input logic [ANGLE_BITS-1:0] x);
    logic [29:0] t30;
    logic [30:0] t;
    t30 = {x[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    t   = x[ANGLE_BITS-2] ? (eaa_pkg::Q30_ONE - {1'b0, t30}) : {1'b0, t30};
    return {x[ANGLE_BITS-1], t};
  endfunction

  // The cosine lane works on the angle advanced by a quarter turn.
  assign a  = ANGLE_BITS'(angle);
  assign ac = a + QUARTER;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      {neg_q[0][0], t_q[0][0]} <= fold(a);
      {neg_q[0][1], t_q[0][1]} <= fold(ac);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < 2; l++) begin
        z_q[1][l] <= eaa_pkg::mul_shr(t_q[0][l], t_q[0][l]);
        t_q[1][l] <= t_q[0][l];
      end
      neg_q[1] <= neg_q[0];
    end
  end

  // Horner's rule in t^2, one coefficient per stage.
  for (genvar k = 2; k <= 6; k++) begin : g_horner
    always_ff @(posedge clk) begin
      if (en[k]) begin
        for (int l = 0; l < 2; l++) begin
          if (k == 2) begin
            p_q[k][l] <= eaa_pkg::SIN_COEF[6-k]
                         - eaa_pkg::mul_shr(eaa_pkg::SIN_COEF[5], z_q[k-1][l]);
          end else begin
            p_q[k][l] <= eaa_pkg::SIN_COEF[6-k]
                         - eaa_pkg::mul_shr(p_q[k-1 < 2 ? 2 : k-1][l], z_q[k-1][l]);
          end
          t_q[k][l] <= t_q[k-1][l];
        end
        neg_q[k] <= neg_q[k-1];
      end
    end
    if (k < 6) begin : g_zpass
      always_ff @(posedge clk) begin
        if (en[k]) begin
          for (int l = 0; l < 2; l++) begin
            z_q[k][l] <= z_q[k-1][l];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int l = 0; l < 2; l++) begin
        logic [30:0] s;
        s = eaa_pkg::mul_shr(p_q[6][l], t_q[6][l]);
        if (s > eaa_pkg::Q30_ONE) begin
          s = eaa_pkg::Q30_ONE;
        end
        out_q[l] <= neg_q[6][l] ? -{1'b0, s} : {1'b0, s};
      end
    end
  end

  assign sin_val = out_q[0];
  assign cos_val = out_q[1];

endmodule

// ===== rtl/eaa_matrix.sv =====
// Pipelined Rz*Ry*Rx column products, sums and conversion to output fields.
module eaa_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic [eaa_pkg::MX_STAGES-1:0]        en,
  input  eaa_pkg::q30_t                        sx,
  input  eaa_pkg::q30_t                        cx,
  input  eaa_pkg::q30_t                        sy,
  input  eaa_pkg::q30_t                        cy,
  input  eaa_pkg::q30_t                        sz,
  input  eaa_pkg::q30_t                        cz,
  output logic [eaa_pkg::FIELD_W-1:0]          fields [9]
);

  localparam int          SH  = 30 - FRAC_BITS;
  localparam logic [33:0] LIM = 34'd1 << FRAC_BITS;

  eaa_pkg::q30_t czcy, szcy, cysx, cycx, szcx, czcx, szsx, czsx, sysx, sycx;
  eaa_pkg::q30_t cz1, sz1;
  eaa_pkg::sum_t nsy1;
  eaa_pkg::q30_t czcy2, szcy2, cysx2, cycx2, szcx2, czcx2, szsx2, czsx2;
  eaa_pkg::q30_t czsysx, szsysx, czsycx, szsycx;
  eaa_pkg::sum_t nsy2;
  eaa_pkg::sum_t sum_q [9];
  logic [eaa_pkg::FIELD_W-1:0] field_q [9];

  // Rounds Q30 to FRAC_BITS, halves away from zero, saturates to +-1.0.
  function automatic logic [eaa_pkg::FIELD_W-1:0] to_field(input eaa_pkg::sum_t v);
    logic [32:0] m;
    logic [33:0] r;
    logic [33:0] s;
    m = v[32] ? 33'(-v) : 33'(v);
    r = (({1'b0, m} << 1) + (34'd1 << SH)) >> (SH + 1);
    if (r > LIM) begin
      r = LIM;
    end
    s = v[32] ? -r : r;
    return s[eaa_pkg::FIELD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      czcy <= eaa_pkg::q30_mul(cz, cy);
      szcy <= eaa_pkg::q30_mul(sz, cy);
      cysx <= eaa_pkg::q30_mul(cy, sx);
      cycx <= eaa_pkg::q30_mul(cy, cx);
      szcx <= eaa_pkg::q30_mul(sz, cx);
      czcx <= eaa_pkg::q30_mul(cz, cx);
      szsx <= eaa_pkg::q30_mul(sz, sx);
      czsx <= eaa_pkg::q30_mul(cz, sx);
      sysx <= eaa_pkg::q30_mul(sy, sx);
      sycx <= eaa_pkg::q30_mul(sy, cx);
      cz1  <= cz;
      sz1  <= sz;
      nsy1 <= -33'(sy);
    end
  end

  // Triple products take the sy term formed in the previous stage.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      czsysx <= eaa_pkg::q30_mul(cz1, sysx);
      szsysx <= eaa_pkg::q30_mul(sz1, sysx);
      czsycx <= eaa_pkg::q30_mul(cz1, sycx);
      szsycx <= eaa_pkg::q30_mul(sz1, sycx);
      czcy2  <= czcy;
      szcy2  <= szcy;
      cysx2  <= cysx;
      cycx2  <= cycx;
      szcx2  <= szcx;
      czcx2  <= czcx;
      szsx2  <= szsx;
      czsx2  <= czsx;
      nsy2   <= nsy1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum_q[0] <= 33'(czcy2);
      sum_q[1] <= 33'(szcy2);
      sum_q[2] <= nsy2;
      sum_q[3] <= 33'(czsysx) - 33'(szcx2);
      sum_q[4] <= 33'(szsysx) + 33'(czcx2);
      sum_q[5] <= 33'(cysx2);
      sum_q[6] <= 33'(czsycx) + 33'(szsx2);
      sum_q[7] <= 33'(szsycx) - 33'(czsx2);
      sum_q[8] <= 33'(cycx2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 9; i++) begin
        field_q[i] <= to_field(sum_q[i]);
      end
    end
  end

  assign fields = field_q;

endmodule

// ===== rtl/euler_angles_to_axes.sv =====
// Top level: Euler angles (pitch, yaw, roll) to the right, up and forward axes of Rz*Ry*Rx.
// The block takes one angle triple per beat and returns the nine Q2.14 axis components;
// with the output side ready it accepts a new beat every cycle. The pipeline is the
// eight-stage sine and cosine evaluation (fold, square, five Horner steps, final product)
// followed by four matrix stages (products, triple products, sums, rounding and
// saturation). Every stage carries its own valid bit and only stalls when the stage after
// it is full and held, so empty slots close up and a waiting result at the output does
// not stop new beats from entering until every stage holds one.
module euler_angles_to_axes #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pitch_angle [15:0], yaw_angle [31:16], roll_angle [47:32]
  input  logic [47:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // right_x, right_y, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z, 16 bits each from bit 0
  output logic [143:0] m_tdata
);

  localparam int NST = eaa_pkg::STAGES;
  localparam int SCN = eaa_pkg::SC_STAGES;

  logic [NST-1:0] v;
  logic [NST:0]   en;

  eaa_pkg::q30_t sx, cx, sy, cy, sz, cz;
  logic [eaa_pkg::FIELD_W-1:0] fields [9];

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NST] = m_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? s_tvalid : v[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  eaa_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en[SCN-1:0]), .angle(s_tdata[15:0]), .sin_val(sx), .cos_val(cx)
  );

  eaa_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en[SCN-1:0]), .angle(s_tdata[31:16]), .sin_val(sy), .cos_val(cy)
  );

  eaa_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en[SCN-1:0]), .angle(s_tdata[47:32]), .sin_val(sz), .cos_val(cz)
  );

  eaa_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .en(en[NST-1:SCN]),
    .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .fields(fields)
  );

  assign s_tready = en[0];
  assign m_tvalid = v[NST-1];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m_tdata[i*eaa_pkg::FIELD_W +: eaa_pkg::FIELD_W] = fields[i];
    end
  end

endmodule

// ===== verif/tb_euler_angles_to_axes.sv =====
// Self-checking testbench for the Euler angle to rotation axes pipeline.
`timescale 1ns / 1ps

module tb_euler_angles_to_axes;

  localparam int ANGLE       = 16;
  localparam int FRAC        = 14;
  localparam int STALL_LIMIT = 2000;
  localparam int CHUNK_ITEMS = 250;
  localparam int CHUNKS      = 7;

  localparam longint unsigned SINE_COEF [6] = '{
    64'd1686629713, 64'd693598669, 64'd85569305, 64'd5026995, 64'd172272, 64'd3864
  };

  logic           clk;
  logic           rst = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [47:0]    s_tdata = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [143:0]   m_tdata;

  bit src_steady;
  bit snk_steady;
  int stall_cycles;

  class axes_scoreboard;
    logic [143:0] expected_axes [$];
    int           sent;
    int           checked;
    int           failures;

    function new();
      sent     = 0;
      checked  = 0;
      failures = 0;
    endfunction

    // Sine over a quarter turn, t in Q30, Horner's rule in t squared.
    function automatic longint unsigned quarter_wave_sine(longint unsigned t);
      longint unsigned z;
      longint unsigned p;
      z = (t * t) >> 30;
      p = SINE_COEF[5];
      for (int k = 4; k >= 0; k--) p = SINE_COEF[k] - ((p * z) >> 30);
      p = (p * t) >> 30;
      if (p > (64'd1 << 30)) p = 64'd1 << 30;
      return p;
    endfunction

    function automatic longint angle_sine(logic [ANGLE-1:0] a);
      logic [1:0]      quad;
      longint unsigned t;
      longint          s;
      quad = a[ANGLE-1:ANGLE-2];
      t    = {50'd0, a[ANGLE-3:0]} << (32 - ANGLE);
      if (quad[0]) t = (64'd1 << 30) - t;
      s = longint'(quarter_wave_sine(t));
      return quad[1] ? -s : s;
    endfunction

    function automatic longint angle_cosine(logic [ANGLE-1:0] a);
      logic [ANGLE-1:0] shifted;
      shifted = a + ANGLE'(1 << (ANGLE - 2));
      return angle_sine(shifted);
    endfunction

    // Q30 by Q30, rounded to nearest with halves away from zero.
    function automatic longint mul_round_q30(longint a, longint b);
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned r;
      ma = (a < 0) ? longint'(-a) : longint'(a);
      mb = (b < 0) ? longint'(-b) : longint'(b);
      r  = (ma * mb + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [eaa_pkg::FIELD_W-1:0] to_axis_field(longint v);
      longint unsigned m;
      longint unsigned lim;
      m   = (v < 0) ? longint'(-v) : longint'(v);
      m   = (m + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      lim = 64'd1 << FRAC;
      if (m > lim) m = lim;
      if (v < 0) m = -m;
      return m[eaa_pkg::FIELD_W-1:0];
    endfunction

    function automatic logic [143:0] predict_axes(logic [15:0] pitch, logic [15:0] yaw,
                                                  logic [15:0] roll);
      longint sx, cx, sy, cy, sz, cz, sysx, sycx;
      logic [143:0] axes;
      sx   = angle_sine(pitch);
      cx   = angle_cosine(pitch);
      sy   = angle_sine(yaw);
      cy   = angle_cosine(yaw);
      sz   = angle_sine(roll);
      cz   = angle_cosine(roll);
      sysx = mul_round_q30(sy, sx);
      sycx = mul_round_q30(sy, cx);
      axes[15:0]    = to_axis_field(mul_round_q30(cz, cy));
      axes[31:16]   = to_axis_field(mul_round_q30(sz, cy));
      axes[47:32]   = to_axis_field(-sy);
      axes[63:48]   = to_axis_field(mul_round_q30(cz, sysx) - mul_round_q30(sz, cx));
      axes[79:64]   = to_axis_field(mul_round_q30(sz, sysx) + mul_round_q30(cz, cx));
      axes[95:80]   = to_axis_field(mul_round_q30(cy, sx));
      axes[111:96]  = to_axis_field(mul_round_q30(cz, sycx) + mul_round_q30(sz, sx));
      axes[127:112] = to_axis_field(mul_round_q30(sz, sycx) - mul_round_q30(cz, sx));
      axes[143:128] = to_axis_field(mul_round_q30(cy, cx));
      return axes;
    endfunction

    function automatic string axis_name(int k);
      case (k)
        0: return "right_x";
        1: return "right_y";
        2: return "right_z";
        3: return "up_x";
        4: return "up_y";
        5: return "up_z";
        6: return "fwd_x";
        7: return "fwd_y";
        default: return "fwd_z";
      endcase
    endfunction

    function void note_angles(logic [15:0] pitch, logic [15:0] yaw, logic [15:0] roll);
      expected_axes.push_back(predict_axes(pitch, yaw, roll));
      sent++;
    endfunction

    function void check_axes(logic [143:0] got);
      logic [143:0] want;
      logic [15:0]  w;
      logic [15:0]  g;
      if (expected_axes.size() == 0) begin
        failures++;
        $error("axes beat arrived with no angle triple outstanding");
        return;
      end
      want = expected_axes.pop_front();
      checked++;
      for (int k = 0; k < 9; k++) begin
        w = want[16*k +: 16];
        g = got[16*k +: 16];
        if (w !== g) begin
          failures++;
          $error("%s: expected %0d, actual %0d", axis_name(k), $signed(w), $signed(g));
        end
      end
    endfunction

    function int pending();
      return expected_axes.size();
    endfunction
  endclass

  axes_scoreboard sb = new();

  euler_angles_to_axes #(
    .ANGLE_BITS(ANGLE),
    .FRAC_BITS (FRAC)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Entered and left at a falling edge; tvalid stays high when no gap follows.
  task automatic send_angles(input logic [15:0] pitch, input logic [15:0] yaw,
                             input logic [15:0] roll);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {roll, yaw, pitch};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_angles(pitch, yaw, roll);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    int unsigned sel;
    int          near;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 16'($urandom);
    if (sel < 85) begin
      // Close to a quadrant boundary, where the fold and the sign change.
      near = ($urandom_range(0, 3) << 14) + $urandom_range(0, 16) - 8;
      return 16'(near);
    end
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h2000 + 16'($urandom_range(0, 3) << 14);
      default: return 16'($urandom_range(0, 3) << 14);
    endcase
  endfunction

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Result side: a random hold-off before each beat, or none in steady phases.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = snk_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_axes(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("euler_angles_to_axes verification failed");
    $finish;
  end

  initial begin
    int mode;
    src_steady = 1'b0;
    snk_steady = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: zero and full-scale angles, quarter turns and their neighbours,
    // and diagonal triples whose sums come near the saturation bound.
    send_angles(16'h0000, 16'h0000, 16'h0000);
    send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_angles(16'h4000, 16'h0000, 16'h0000);
    send_angles(16'h0000, 16'h4000, 16'h0000);
    send_angles(16'h0000, 16'h0000, 16'h4000);
    send_angles(16'h4000, 16'h4000, 16'h4000);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'hC000, 16'hC000, 16'hC000);
    send_angles(16'h3FFF, 16'h4001, 16'hBFFF);
    send_angles(16'h7FFF, 16'h8001, 16'hC001);
    send_angles(16'h0001, 16'hFFFF, 16'h8000);
    send_angles(16'h2000, 16'h2000, 16'h2000);
    send_angles(16'hE000, 16'h2000, 16'h6000);
    send_angles(16'h6000, 16'hA000, 16'hE000);
    send_angles(16'h2000, 16'h0000, 16'h2000);
    send_angles(16'h1555, 16'h2AAA, 16'h5555);
    send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
    send_angles(16'h5555, 16'hAAAA, 16'h5555);
    send_angles(16'h0000, 16'hC000, 16'h4000);
    send_angles(16'hFFFF, 16'h0000, 16'hFFFF);

    for (int c = 0; c < CHUNKS; c++) begin
      // Chunk one runs without any idling, chunk two idles on both sides.
      mode = (c == 1) ? 3 : (c == 2) ? 0 : $urandom_range(0, 3);
      src_steady = mode[0];
      snk_steady = mode[1];
      for (int i = 0; i < CHUNK_ITEMS; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
      if (c == 3) wait_for_drain();
    end
    wait_for_drain();
    repeat (2 * eaa_pkg::STAGES) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.failures++;
      $error("%0d axes beats never arrived", sb.pending());
    end
    $display("Sent %0d angle triples and checked %0d axis beats across idle, steady",
             sb.sent, sb.checked);
    $display("and drained phases, with quadrant edges and full-scale angles included.");
    if (sb.failures == 0) begin
      $display("euler_angles_to_axes verification clean");
    end else begin
      $display("euler_angles_to_axes verification failed");
    end
    $finish;
  end

endmodule
